### hw/rtl/tdf_pkg.sv
`default_nettype none

package tdf_pkg;

    // Operand width of the factorizer
    localparam int VALUE_WIDTH = 32;
    // Odd trial divisors stay below 2^(VALUE_WIDTH/2) + 2
    localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 1;
    // Restoring divider step counter
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TWOS,
        S_DIV,
        S_EVAL
    } t_state;

    typedef enum logic [2:0] {
        EMIT_OFF,
        EMIT_NONE,
        EMIT_TWO,
        EMIT_DIV,
        EMIT_LEFT
    } t_emit;

    typedef struct packed {
        logic  load;        // take the request value, set divisor to three
        logic  shift2;      // drop one factor of two
        logic  div_start;   // load the divider
        logic  div_step;    // one restoring step
        logic  take_quo;    // cofactor gets the quotient
        logic  bump;        // advance divisor by two
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic zero_one;     // request value is 0 or 1
        logic cof_even;
        logic cof_gt1;
        logic div_last;     // current step is the final one
        logic rem_zero;
        logic bound_fail;   // divisor exceeds cofactor / divisor
    } t_stat;

endpackage

`default_nettype wire

### hw/rtl/tdf_ctrl.sv
`default_nettype none

module tdf_ctrl import tdf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;
    logic   r_inner, n_inner;   // last division was exact: skip the bound test

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_inner <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inner <= n_inner;
        end
    end

    always_comb begin
        n_state = r_state;
        n_inner = r_inner;
        o_cmd   = '{load: 1'b0, shift2: 1'b0, div_start: 1'b0, div_step: 1'b0,
                    take_quo: 1'b0, bump: 1'b0, emit: EMIT_OFF};
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_stat.zero_one) begin
                        o_cmd.emit = EMIT_NONE;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_TWOS;
                    end
                end
            end
            S_TWOS: begin
                if (i_stat.cof_even) begin
                    o_cmd.shift2 = 1'b1;
                    o_cmd.emit   = EMIT_TWO;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_inner         = 1'b0;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!r_inner && i_stat.bound_fail) begin
                    if (i_stat.cof_gt1) begin
                        o_cmd.emit = EMIT_LEFT;
                    end
                    n_state = S_IDLE;
                end else if (i_stat.rem_zero) begin
                    o_cmd.take_quo  = 1'b1;
                    o_cmd.emit      = EMIT_DIV;
                    o_cmd.div_start = 1'b1;
                    n_inner         = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.bump      = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_inner         = 1'b0;
                    n_state         = S_DIV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

### hw/rtl/tdf_dpath.sv
`default_nettype none

module tdf_dpath import tdf_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire t_cmd                   i_cmd,
    output t_stat                       o_stat,
    output logic                        o_valid,
    output logic [VALUE_WIDTH-1:0]      o_factor,
    output logic                        o_last,
    output logic                        o_none
);

    logic [VALUE_WIDTH-1:0] r_cof;
    logic [DIV_WIDTH-1:0]   r_div;
    logic [VALUE_WIDTH-1:0] r_quo;     // dividend shifts out, quotient shifts in
    logic [DIV_WIDTH-1:0]   r_rem;
    logic [CNT_WIDTH-1:0]   r_cnt;
    logic                   r_valid;
    logic [VALUE_WIDTH-1:0] r_factor;
    logic                   r_last;
    logic                   r_none;

    logic [DIV_WIDTH:0]     rem_sh;
    logic [DIV_WIDTH:0]     diff;
    logic                   q_bit;
    logic [VALUE_WIDTH-1:0] div_ext;
    logic [VALUE_WIDTH-1:0] n_cof;

    assign div_ext = {{(VALUE_WIDTH-DIV_WIDTH){1'b0}}, r_div};
    assign rem_sh  = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign diff    = rem_sh - {1'b0, r_div};
    assign q_bit   = ~diff[DIV_WIDTH];

    assign n_cof = i_cmd.take_quo ? r_quo : r_cof;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cof <= i_value;
            r_div <= DIV_WIDTH'(3);
        end else begin
            if (i_cmd.shift2) begin
                r_cof <= {1'b0, r_cof[VALUE_WIDTH-1:1]};
            end else if (i_cmd.take_quo) begin
                r_cof <= r_quo;
            end
            if (i_cmd.bump) begin
                r_div <= r_div + DIV_WIDTH'(2);
            end
        end

        if (i_cmd.div_start) begin
            r_quo <= n_cof;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[VALUE_WIDTH-2:0], q_bit};
            r_rem <= q_bit ? diff[DIV_WIDTH-1:0] : rem_sh[DIV_WIDTH-1:0];
        end

        unique case (i_cmd.emit)
            EMIT_NONE: begin
                r_factor <= '0;
                r_last   <= 1'b1;
                r_none   <= 1'b1;
            end
            EMIT_TWO: begin
                r_factor <= VALUE_WIDTH'(2);
                r_last   <= (r_cof == VALUE_WIDTH'(2));
                r_none   <= 1'b0;
            end
            EMIT_DIV: begin
                r_factor <= div_ext;
                r_last   <= (r_quo == VALUE_WIDTH'(1));
                r_none   <= 1'b0;
            end
            EMIT_LEFT: begin
                r_factor <= r_cof;
                r_last   <= 1'b1;
                r_none   <= 1'b0;
            end
            default: begin
                r_factor <= r_factor;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.emit != EMIT_OFF);
            if (i_cmd.div_start) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + CNT_WIDTH'(1);
            end
        end
    end

    always_comb begin
        o_stat.zero_one   = (i_value[VALUE_WIDTH-1:1] == '0);
        o_stat.cof_even   = ~r_cof[0];
        o_stat.cof_gt1    = (r_cof > VALUE_WIDTH'(1));
        o_stat.div_last   = (r_cnt == CNT_WIDTH'(VALUE_WIDTH - 1));
        o_stat.rem_zero   = (r_rem == '0);
        o_stat.bound_fail = (div_ext > r_quo);
    end

    assign o_valid  = r_valid;
    assign o_factor = r_factor;
    assign o_last   = r_last;
    assign o_none   = r_none;

endmodule

`default_nettype wire

### hw/rtl/trial_division_factorizer_core.sv
`default_nettype none
// Channel   | Ports                            | Handshake
// ----------+----------------------------------+------------------------------------
// request   | i_value                          | taken when i_start & !o_busy
// result    | o_factor, o_last, o_none         | o_valid strobe, one cycle each
//
// A request of 0 or 1 is answered with one none result the cycle after it is
// taken; o_busy stays low. Otherwise each factor of two is dropped by its own
// step of the twos loop, and each division by an odd trial divisor takes 32
// restoring steps of the shared divider and then one evaluate step.
// Reset is synchronous, active low, and returns the controller to idle.
// The receiver cannot stall: every result is shown for exactly one cycle.

module trial_division_factorizer_core import tdf_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    output logic                        o_busy,
    output logic                        o_valid,
    output logic [VALUE_WIDTH-1:0]      o_factor,
    output logic                        o_last,
    output logic                        o_none
);

    t_cmd  cmd;
    t_stat stat;
    logic  accept;

    // Hold the request off while a value is being factored
    assign accept = i_start & ~o_busy;

    // Controller: sequences the twos loop, the divisions and the evaluations
    tdf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // Datapath: cofactor, trial divisor, restoring divider, result register
    tdf_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_value),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_factor (o_factor),
        .o_last   (o_last),
        .o_none   (o_none)
    );

    // A none result is always the single, final one and carries factor zero
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_none) |-> (o_last && o_factor == '0))
        else $error("none result without last or with nonzero factor");

    // Any real factor is at least two
    a_factor_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_none) |-> (o_factor > VALUE_WIDTH'(1)))
        else $error("factor below two");

    // A request of 2 or more enters the factoring loop
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !stat.zero_one) |=> o_busy)
        else $error("request of 2 or more not taken into work");

    // A request of 0 or 1 gives its none result in the next cycle
    a_small_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && stat.zero_one) |=> (o_valid && o_none))
        else $error("missing none result");

endmodule

`default_nettype wire
